// ===== hw/rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every clock edge out of reset.
`define JCA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition in one cycle is followed by another in the next.
`define JCA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/jca_pkg.sv =====
package jca_pkg;

  localparam int MAX_PIXELS_DEF = 4096;
  localparam int VALUE_BITS_DEF = 32;

  localparam int SAMPLE_W   = 32;
  localparam int SUM_W      = 40;
  localparam int SPP_W      = 9;
  localparam int PCNT_W     = 13;
  localparam int PIX_IDX_W  = 12;
  localparam int COLOR_W    = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;
  localparam int GROUP_MAX  = 256;
  localparam int NORM_SHIFT = 18;
  localparam int T_BITS     = 20;
  localparam int Q_ONE      = 65536;

  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES_PER_PIXEL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_COUNT       = 1'b1;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam int RED_LO   = 98304;
  localparam int RED_HI   = 294912;
  localparam int GREEN_LO = 32768;
  localparam int GREEN_HI = 229376;
  localparam int BLUE_LO  = -32768;
  localparam int BLUE_HI  = 163840;

  localparam logic [COLOR_W-1:0] COLOR_FULL = {COLOR_W{1'b1}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AVG_START,
    ST_AVG_WAIT,
    ST_STORE,
    ST_RD_WAIT,
    ST_NORM_START,
    ST_NORM_WAIT,
    ST_EMIT
  } seq_state_e;

  typedef struct packed {
    logic start;
    logic floor_mode;
  } div_ctrl_t;

  typedef struct packed {
    logic                 valid;
    logic                 white;
    logic [T_BITS-1:0]    t;
    logic [PIX_IDX_W-1:0] index;
  } color_req_t;

endpackage

// ===== hw/rtl/jca_divider.sv =====
`include "assert_macros.svh"

module jca_divider import jca_pkg::*; #(
  parameter int NUM_W = 50,
  parameter int DEN_W = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  div_ctrl_t               ctrl_i,
  input  logic signed [NUM_W:0]   num_i,
  input  logic        [DEN_W-1:0] den_i,
  output logic                    busy_o,
  output logic                    done_o,
  output logic signed [NUM_W:0]   quot_o
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             neg_q;
  logic             floor_q;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W-1:0] rem_q;
  logic [NUM_W-1:0] sh_q;

  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;
  logic [NUM_W:0]   num_mag;
  logic [NUM_W:0]   q_mag;

  assign trial   = {rem_q, sh_q[NUM_W-1]};
  assign diff    = trial - {1'b0, den_q};
  assign ge      = trial >= {1'b0, den_q};
  assign num_mag = num_i[NUM_W] ? -num_i : num_i;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    if (ctrl_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(NUM_W);
    end else if (busy_q) begin
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      neg_q   <= num_i[NUM_W];
      floor_q <= ctrl_i.floor_mode;
      den_q   <= den_i;
      rem_q   <= '0;
      sh_q    <= num_mag[NUM_W-1:0];
    end else if (busy_q) begin
      rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      sh_q  <= {sh_q[NUM_W-2:0], ge};
    end
  end

  always_comb begin
    q_mag = (NUM_W + 1)'(sh_q);
    if (!neg_q) begin
      quot_o = q_mag;
    end else if (floor_q && (rem_q != '0)) begin
      quot_o = ~q_mag;
    end else begin
      quot_o = -q_mag;
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;

  `JCA_ASSERT(a_done_ends_busy, clk_i, rst_ni, done_q |-> !busy_q && $past(busy_q), "done without a finished run")
  `JCA_ASSERT(a_no_start_busy, clk_i, rst_ni, ctrl_i.start |-> !busy_q, "start while a division runs")
  `JCA_ASSERT_NEXT(a_start_runs, clk_i, rst_ni, ctrl_i.start, busy_q && !done_q, "start did not begin a run")

endmodule

// ===== hw/rtl/jca_value_store.sv =====
module jca_value_store import jca_pkg::*; #(
  parameter int DEPTH = MAX_PIXELS_DEF,
  parameter int WIDTH = VALUE_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

// ===== hw/rtl/jca_color.sv =====
module jca_color import jca_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  color_req_t           req_i,
  output logic                 valid_o,
  output logic [COLOR_W-1:0]   red_o,
  output logic [COLOR_W-1:0]   green_o,
  output logic [COLOR_W-1:0]   blue_o,
  output logic [PIX_IDX_W-1:0] pixel_number_o
);

  localparam int CW = T_BITS + 2;

  function automatic logic [COLOR_W-1:0] chan(input logic signed [CW-1:0] t,
                                              input logic signed [CW-1:0] lo_off,
                                              input logic signed [CW-1:0] hi_off);
    logic signed [CW-1:0] lo;
    logic signed [CW-1:0] hi;
    logic signed [CW-1:0] m;
    logic [15:0]          frac;
    logic [23:0]          prod;
    lo   = t - lo_off;
    hi   = hi_off - t;
    m    = (lo < hi) ? lo : hi;
    frac = m[15:0];
    prod = {frac, 8'h00} - {8'h00, frac};
    if (m <= 0) begin
      return '0;
    end else if (m >= CW'(Q_ONE)) begin
      return COLOR_FULL;
    end else begin
      return prod[23:16];
    end
  endfunction

  logic                 valid_q;
  logic signed [CW-1:0] t_x;

  assign t_x = CW'($signed(req_i.t));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid) begin
      pixel_number_o <= req_i.index;
      if (req_i.white) begin
        red_o   <= COLOR_FULL;
        green_o <= COLOR_FULL;
        blue_o  <= COLOR_FULL;
      end else begin
        red_o   <= chan(t_x, CW'(RED_LO), CW'(RED_HI));
        green_o <= chan(t_x, CW'(GREEN_LO), CW'(GREEN_HI));
        blue_o  <= chan(t_x, CW'(BLUE_LO), CW'(BLUE_HI));
      end
    end
  end

  assign valid_o = valid_q;

endmodule

// ===== hw/rtl/jet_colormap_autorange.sv =====
// Jet colormap with automatic range.
// Command channel: an op is taken at a clock edge with start_i high and
// busy_o low. op_i = 0 loads sample_i (signed Q16.16); op_i = 1 reads the
// pixel at pixel_index_i and returns its jet color.
// A load that does not close a group leaves busy_o low.
// A load that closes a group runs the averaging division and stores the
// pixel with busy_o high throughout; the shared one-bit-per-cycle divider
// yields NW = max(40, VALUE_BITS + 18) quotient bits (50 by default).
// The frame range is latched when a frame fills.
// A read issues valid_o with red_o, green_o, blue_o and pixel_number_o
// through the states RD_WAIT, NORM_START, NORM_WAIT and EMIT, then the
// color register; an empty range (white) skips NORM_START and NORM_WAIT.
// busy_o drops in the same cycle the result is shown.
// valid_o is high for exactly one cycle per read; there is no back
// pressure on results. Configuration writes go through cfg_valid_i /
// cfg_ready_o (always ready) and must be made only while idle; the block
// does not enforce this. Reset clears sequencer, group, frame and range
// state; the value store is not cleared by reset.
`include "assert_macros.svh"

module jet_colormap_autorange import jca_pkg::*; #(
  parameter int MAX_PIXELS = MAX_PIXELS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  output logic                   busy_o,
  input  logic                   op_i,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  input  logic [PIX_IDX_W-1:0]   pixel_index_i,
  output logic                   valid_o,
  output logic [COLOR_W-1:0]     red_o,
  output logic [COLOR_W-1:0]     green_o,
  output logic [COLOR_W-1:0]     blue_o,
  output logic [PIX_IDX_W-1:0]   pixel_number_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int VB    = VALUE_BITS;
  localparam int AW    = $clog2(MAX_PIXELS);
  localparam int XW    = ((AW > PIX_IDX_W) ? AW : PIX_IDX_W) + 1;
  localparam int FW    = ((AW + 1) > PCNT_W) ? (AW + 1) : PCNT_W;
  localparam int NUM_W = ((VB + NORM_SHIFT) > SUM_W) ? (VB + NORM_SHIFT) : SUM_W;
  localparam int NSW   = NUM_W + 1;

  localparam logic signed [VB-1:0]  VAL_MAX_V = {1'b0, {(VB-1){1'b1}}};
  localparam logic signed [VB-1:0]  VAL_MIN_V = {1'b1, {(VB-1){1'b0}}};
  localparam logic signed [NSW-1:0] VMAX_W    = {{(NSW-VB+1){1'b0}}, {(VB-1){1'b1}}};
  localparam logic signed [NSW-1:0] VMIN_W    = ~VMAX_W;
  localparam logic signed [NSW-1:0] T_HI      = NSW'(2**(T_BITS-1) - 1);
  localparam logic signed [NSW-1:0] T_LO      = ~T_HI;

  seq_state_e state_q, state_d;

  logic [SPP_W-1:0]         spp_q;
  logic [PCNT_W-1:0]        pc_q;
  logic signed [SUM_W-1:0]  sum_q;
  logic [SPP_W-1:0]         fill_q;
  logic [AW-1:0]            pos_q;
  logic signed [VB-1:0]     rmin_q, rmax_q;
  logic signed [VB-1:0]     lmin_q, lmax_q;
  logic signed [VB-1:0]     v_q;
  logic signed [VB:0]       diff_q;
  logic [T_BITS-1:0]        t_q;
  logic                     white_q;
  logic [PIX_IDX_W-1:0]     idx_q;
  logic                     in_range_q;

  logic                     accept;
  logic [SPP_W-1:0]         group_n;
  logic [SPP_W-1:0]         fill_inc;
  logic                     group_close;
  logic [XW-1:0]            idx_x;
  logic                     in_range;
  logic [FW-1:0]            pc_x;
  logic [FW-1:0]            frame_n;
  logic [FW-1:0]            pos_next;
  logic                     frame_close;
  logic signed [VB:0]       range_w;
  logic                     range_pos;
  logic signed [VB-1:0]     x_w;
  logic signed [VB+NORM_SHIFT:0] norm_num;
  logic signed [VB-1:0]     sat_v;
  logic signed [VB-1:0]     new_min, new_max;
  logic [VB-1:0]            rd_data;

  div_ctrl_t                div_ctrl;
  logic signed [NSW-1:0]    div_num;
  logic [VB-1:0]            div_den;
  logic                     div_busy;
  logic                     div_done;
  logic signed [NSW-1:0]    div_quot;
  logic                     mem_we;
  color_req_t               color_req;

  assign busy_o      = (state_q != ST_IDLE);
  assign accept      = start_i && !busy_o;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    if (spp_q == '0) begin
      group_n = SPP_W'(1);
    end else if (spp_q > SPP_W'(GROUP_MAX)) begin
      group_n = SPP_W'(GROUP_MAX);
    end else begin
      group_n = spp_q;
    end
  end

  assign fill_inc    = fill_q + SPP_W'(1);
  assign group_close = (fill_inc >= group_n);

  assign idx_x    = XW'(pixel_index_i);
  assign in_range = (idx_x < XW'(MAX_PIXELS));

  assign pc_x = FW'(pc_q);
  always_comb begin
    if (pc_x == '0) begin
      frame_n = FW'(1);
    end else if (pc_x > FW'(MAX_PIXELS)) begin
      frame_n = FW'(MAX_PIXELS);
    end else begin
      frame_n = pc_x;
    end
  end

  assign pos_next    = FW'(pos_q) + FW'(1);
  assign frame_close = (pos_next >= frame_n);

  assign range_w   = (VB+1)'(lmax_q) - (VB+1)'(lmin_q);
  assign range_pos = !range_w[VB] && (range_w != '0);

  assign x_w      = in_range_q ? $signed(rd_data) : '0;
  assign norm_num = (VB+NORM_SHIFT+1)'(diff_q) <<< NORM_SHIFT;

  always_comb begin
    if (div_quot > VMAX_W) begin
      sat_v = VAL_MAX_V;
    end else if (div_quot < VMIN_W) begin
      sat_v = VAL_MIN_V;
    end else begin
      sat_v = div_quot[VB-1:0];
    end
  end

  assign new_min = (v_q < rmin_q) ? v_q : rmin_q;
  assign new_max = (v_q > rmax_q) ? v_q : rmax_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (op_i)
            OP_READ: state_d = ST_RD_WAIT;
            OP_LOAD: state_d = group_close ? ST_AVG_START : ST_IDLE;
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_AVG_START:  state_d = ST_AVG_WAIT;
      ST_AVG_WAIT:   state_d = div_done ? ST_STORE : ST_AVG_WAIT;
      ST_STORE:      state_d = ST_IDLE;
      ST_RD_WAIT:    state_d = range_pos ? ST_NORM_START : ST_EMIT;
      ST_NORM_START: state_d = ST_NORM_WAIT;
      ST_NORM_WAIT:  state_d = div_done ? ST_EMIT : ST_NORM_WAIT;
      ST_EMIT:       state_d = ST_IDLE;
      default:       state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    div_ctrl.start      = (state_q == ST_AVG_START) || (state_q == ST_NORM_START);
    div_ctrl.floor_mode = (state_q == ST_NORM_START);
    div_num             = div_ctrl.floor_mode ? NSW'(norm_num) : NSW'(sum_q);
    div_den             = div_ctrl.floor_mode ? range_w[VB-1:0] : VB'(group_n);
    mem_we              = (state_q == ST_STORE);
    color_req.valid     = (state_q == ST_EMIT);
    color_req.white     = white_q;
    color_req.t         = t_q;
    color_req.index     = idx_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spp_q <= SPP_W'(1);
      pc_q  <= PCNT_W'(4096);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_SAMPLES_PER_PIXEL: spp_q <= cfg_data_i[SPP_W-1:0];
        CFG_PIXEL_COUNT:       pc_q  <= cfg_data_i[PCNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      fill_q <= '0;
      pos_q  <= '0;
      rmin_q <= VAL_MAX_V;
      rmax_q <= VAL_MIN_V;
      lmin_q <= '0;
      lmax_q <= '0;
    end else if (accept && (op_i == OP_LOAD)) begin
      sum_q  <= sum_q + SUM_W'(sample_i);
      fill_q <= group_close ? '0 : fill_inc;
    end else if (state_q == ST_STORE) begin
      sum_q <= '0;
      if (frame_close) begin
        lmin_q <= new_min;
        lmax_q <= new_max;
        rmin_q <= VAL_MAX_V;
        rmax_q <= VAL_MIN_V;
        pos_q  <= '0;
      end else begin
        rmin_q <= new_min;
        rmax_q <= new_max;
        pos_q  <= pos_next[AW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && (op_i == OP_READ)) begin
      idx_q      <= pixel_index_i;
      in_range_q <= in_range;
    end
    if ((state_q == ST_AVG_WAIT) && div_done) begin
      v_q <= sat_v;
    end
    if (state_q == ST_RD_WAIT) begin
      diff_q  <= (VB+1)'(x_w) - (VB+1)'(lmin_q);
      white_q <= !range_pos;
    end
    if ((state_q == ST_NORM_WAIT) && div_done) begin
      if (div_quot > T_HI) begin
        t_q <= T_HI[T_BITS-1:0];
      end else if (div_quot < T_LO) begin
        t_q <= T_LO[T_BITS-1:0];
      end else begin
        t_q <= div_quot[T_BITS-1:0];
      end
    end
  end

  jca_divider #(
    .NUM_W (NUM_W),
    .DEN_W (VB)
  ) u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (div_ctrl),
    .num_i  (div_num),
    .den_i  (div_den),
    .busy_o (div_busy),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  jca_value_store #(
    .DEPTH (MAX_PIXELS),
    .WIDTH (VB)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (mem_we),
    .wr_addr_i (pos_q),
    .wr_data_i (v_q),
    .rd_en_i   (accept && (op_i == OP_READ)),
    .rd_addr_i (idx_x[AW-1:0]),
    .rd_data_o (rd_data)
  );

  jca_color u_color (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_i          (color_req),
    .valid_o        (valid_o),
    .red_o          (red_o),
    .green_o        (green_o),
    .blue_o         (blue_o),
    .pixel_number_o (pixel_number_o)
  );

  `JCA_ASSERT(a_result_after_emit, clk_i, rst_ni, valid_o |-> $past(state_q == ST_EMIT), "result without a finished read")
  `JCA_ASSERT(a_div_idle_when_ready, clk_i, rst_ni, (state_q == ST_IDLE) |-> !div_busy, "divider runs while sequencer is idle")
  `JCA_ASSERT_NEXT(a_store_returns, clk_i, rst_ni, (state_q == ST_AVG_WAIT) && div_done, (state_q == ST_STORE) && !div_busy, "average result not stored")

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import jca_pkg::*;

  localparam longint VAL_MAX = (longint'(1) <<< (VALUE_BITS_DEF - 1)) - 1;
  localparam longint VAL_MIN = -VAL_MAX - 1;

  typedef struct {
    logic [COLOR_W-1:0]   red;
    logic [COLOR_W-1:0]   green;
    logic [COLOR_W-1:0]   blue;
    logic [PIX_IDX_W-1:0] number;
  } pixel_color_t;

  class jet_color_scoreboard;
    longint         pixel_value [MAX_PIXELS_DEF];
    bit             stored [MAX_PIXELS_DEF];
    int unsigned    written_list [$];
    longint         group_sum;
    int unsigned    group_fill;
    int unsigned    write_pos;
    longint         run_min;
    longint         run_max;
    longint         lat_min;
    longint         lat_max;
    logic [SPP_W-1:0]  spp;
    logic [PCNT_W-1:0] pcnt;
    pixel_color_t   pending_colors [$];
    int unsigned    mismatches;

    function new();
      group_sum  = 0;
      group_fill = 0;
      write_pos  = 0;
      run_min    = VAL_MAX;
      run_max    = VAL_MIN;
      lat_min    = 0;
      lat_max    = 0;
      spp        = SPP_W'(1);
      pcnt       = PCNT_W'(MAX_PIXELS_DEF);
      mismatches = 0;
    endfunction

    task report(input string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      mismatches++;
    endtask

    function void set_register(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_SAMPLES_PER_PIXEL) begin
        spp = data[SPP_W-1:0];
      end else begin
        pcnt = data[PCNT_W-1:0];
      end
    endfunction

    function logic [COLOR_W-1:0] channel_level(input longint t, input longint a,
                                               input longint b);
      longint lo;
      longint hi;
      longint m;
      lo = t - a;
      hi = b - t;
      m  = (lo < hi) ? lo : hi;
      if (m <= 0) return '0;
      if (m >= longint'(Q_ONE)) return COLOR_FULL;
      return COLOR_W'((255 * m) >>> 16);
    endfunction

    function void store_pixel(input longint v);
      int unsigned frame;
      frame = (pcnt == 0) ? 1 : ((pcnt > MAX_PIXELS_DEF) ? MAX_PIXELS_DEF : pcnt);
      if (write_pos < MAX_PIXELS_DEF) begin
        pixel_value[write_pos] = v;
        if (!stored[write_pos]) begin
          stored[write_pos] = 1'b1;
          written_list.insert(written_list.size(), write_pos);
        end
      end
      if (v < run_min) run_min = v;
      if (v > run_max) run_max = v;
      write_pos++;
      if (write_pos >= frame) begin
        lat_min   = run_min;
        lat_max   = run_max;
        run_min   = VAL_MAX;
        run_max   = VAL_MIN;
        write_pos = 0;
      end
    endfunction

    function void accept_item(input logic op, input logic signed [SAMPLE_W-1:0] smp,
                              input logic [PIX_IDX_W-1:0] idx);
      int unsigned  n;
      longint       v;
      longint       x;
      longint       range;
      longint       num;
      longint       t;
      pixel_color_t c;
      if (op == OP_LOAD) begin
        n = (spp == 0) ? 1 : ((spp > GROUP_MAX) ? GROUP_MAX : spp);
        group_sum += longint'(smp);
        group_fill++;
        if (group_fill >= n) begin
          v = group_sum / longint'(n);
          if (v > VAL_MAX) v = VAL_MAX;
          if (v < VAL_MIN) v = VAL_MIN;
          group_sum  = 0;
          group_fill = 0;
          store_pixel(v);
        end
      end else begin
        x = (idx < MAX_PIXELS_DEF) ? pixel_value[idx] : 0;
        range = lat_max - lat_min;
        c.red = COLOR_FULL;
        c.green = COLOR_FULL;
        c.blue = COLOR_FULL;
        c.number = idx;
        if (range > 0) begin
          num = (x - lat_min) * 4 * longint'(Q_ONE);
          t = num / range;
          if ((num % range != 0) && (num < 0)) t -= 1;
          c.red   = channel_level(t, RED_LO, RED_HI);
          c.green = channel_level(t, GREEN_LO, GREEN_HI);
          c.blue  = channel_level(t, BLUE_LO, BLUE_HI);
        end
        pending_colors.insert(pending_colors.size(), c);
      end
    endfunction

    task check_color(input logic [COLOR_W-1:0] r, input logic [COLOR_W-1:0] g,
                     input logic [COLOR_W-1:0] b, input logic [PIX_IDX_W-1:0] n);
      pixel_color_t want;
      if (pending_colors.size() == 0) begin
        report($sformatf("color for pixel %0d with no read outstanding", n));
      end else begin
        want = pending_colors.pop_front();
        if (n !== want.number)
          report($sformatf("pixel_number %0d, want %0d", n, want.number));
        if (r !== want.red)
          report($sformatf("pixel %0d red %0d, want %0d", want.number, r, want.red));
        if (g !== want.green)
          report($sformatf("pixel %0d green %0d, want %0d", want.number, g, want.green));
        if (b !== want.blue)
          report($sformatf("pixel %0d blue %0d, want %0d", want.number, b, want.blue));
      end
    endtask
  endclass

  logic                         clk_i;
  logic                         rst_ni;
  logic                         start_i;
  logic                         busy_o;
  logic                         op_i;
  logic signed [SAMPLE_W-1:0]   sample_i;
  logic [PIX_IDX_W-1:0]         pixel_index_i;
  logic                         valid_o;
  logic [COLOR_W-1:0]           red_o;
  logic [COLOR_W-1:0]           green_o;
  logic [COLOR_W-1:0]           blue_o;
  logic [PIX_IDX_W-1:0]         pixel_number_o;
  logic                         cfg_valid_i;
  logic                         cfg_ready_o;
  logic [CFG_IDX_W-1:0]         cfg_index_i;
  logic [CFG_DATA_W-1:0]        cfg_data_i;

  jet_color_scoreboard book;

  jet_colormap_autorange dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .op_i           (op_i),
    .sample_i       (sample_i),
    .pixel_index_i  (pixel_index_i),
    .valid_o        (valid_o),
    .red_o          (red_o),
    .green_o        (green_o),
    .blue_o         (blue_o),
    .pixel_number_o (pixel_number_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      book.check_color(red_o, green_o, blue_o, pixel_number_o);
    end
  end

  task automatic issue(input logic op, input logic signed [SAMPLE_W-1:0] smp,
                       input logic [PIX_IDX_W-1:0] idx);
    start_i       <= 1'b1;
    op_i          <= op;
    sample_i      <= smp;
    pixel_index_i <= idx;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    book.accept_item(op, smp, idx);
  endtask

  task automatic wait_drained();
    while (book.pending_colors.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    book.set_register(idx, data);
  endtask

  task automatic configure(input int unsigned spp, input int unsigned pc);
    start_i <= 1'b0;
    wait_drained();
    // let a group-closing load finish its division
    repeat (64) @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    write_reg(CFG_SAMPLES_PER_PIXEL, {4'($urandom()), SPP_W'(spp)});
    write_reg(CFG_PIXEL_COUNT, CFG_DATA_W'(pc));
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_phase(input int unsigned spp, input int unsigned pc,
                           input int unsigned items, input int unsigned read_pct);
    int unsigned                burst_left;
    int unsigned                gap;
    logic                       op;
    logic signed [SAMPLE_W-1:0] smp;
    logic [PIX_IDX_W-1:0]       idx;
    logic signed [SAMPLE_W-1:0] base;
    logic [SAMPLE_W-1:0]        mask;
    configure(spp, pc);
    base = $urandom();
    mask = (32'd1 << $urandom_range(4, 26)) - 1;
    burst_left = $urandom_range(1, 24);
    repeat (items) begin
      if (burst_left == 0) begin
        start_i <= 1'b0;
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 70) : $urandom_range(1, 4);
        repeat (gap) @(posedge clk_i);
        if ($urandom_range(0, 149) == 0) wait_drained();
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 160)
                                                 : $urandom_range(1, 24);
      end
      burst_left--;
      if (book.written_list.size() != 0 && $urandom_range(0, 99) < read_pct) begin
        op  = OP_READ;
        idx = PIX_IDX_W'(book.written_list[$urandom_range(0, book.written_list.size() - 1)]);
        smp = $urandom();
      end else begin
        op  = OP_LOAD;
        idx = PIX_IDX_W'($urandom_range(0, MAX_PIXELS_DEF - 1));
        case ($urandom_range(0, 9))
          0: smp = $urandom();
          1: smp = $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
          default: smp = base + ($urandom() & mask);
        endcase
      end
      issue(op, smp, idx);
    end
  endtask

  initial begin
    book          = new();
    rst_ni        = 1'b0;
    start_i       = 1'b0;
    op_i          = OP_LOAD;
    sample_i      = '0;
    pixel_index_i = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CFG_SAMPLES_PER_PIXEL;
    cfg_data_i    = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // no frame latched yet: reads come back white
    issue(OP_LOAD, 32'sh8000_0000, 12'd0);
    issue(OP_LOAD, 32'sh7fff_ffff, 12'hfff);
    issue(OP_LOAD, 32'sh0000_0000, 12'd0);
    issue(OP_LOAD, 32'sh0001_0000, 12'hfff);
    issue(OP_READ, 32'sh7fff_ffff, 12'd0);
    issue(OP_READ, 32'sh8000_0000, 12'd3);

    // shrink the frame below the write position: next store latches
    configure(1, 4);
    issue(OP_LOAD, 32'shffff_0000, 12'd0);
    issue(OP_READ, '0, 12'd0);
    issue(OP_READ, '0, 12'd1);
    issue(OP_READ, '0, 12'd2);
    issue(OP_READ, '0, 12'd3);
    issue(OP_READ, '0, 12'd4);

    // averages truncate toward zero; pixel 4 falls below the new range
    configure(2, 3);
    issue(OP_LOAD, -32'sd3, 12'd0);
    issue(OP_LOAD, 32'sd0, 12'd0);
    issue(OP_LOAD, 32'sd5, 12'd0);
    issue(OP_LOAD, 32'sd2, 12'd0);
    issue(OP_LOAD, 32'sh7fff_ffff, 12'd0);
    issue(OP_LOAD, 32'sh7fff_ffff, 12'd0);
    issue(OP_READ, '0, 12'd0);
    issue(OP_READ, '0, 12'd1);
    issue(OP_READ, '0, 12'd2);
    issue(OP_READ, '0, 12'd4);

    // zero group size and zero pixel count: single-pixel frames, empty range
    configure(0, 0);
    issue(OP_LOAD, 32'sh0000_1234, 12'd0);
    issue(OP_READ, '0, 12'd0);

    run_phase(1, 800, 880, 8);
    run_phase(0, 0, 30, 40);
    run_phase(3, 5, 80, 30);
    run_phase(1, 2, 80, 40);
    run_phase(256, 4096, 270, 4);
    run_phase(511, 8191, 270, 4);
    run_phase(2, 7, 100, 30);
    run_phase(1, 1, 40, 40);
    repeat (3) run_phase($urandom_range(1, 6), $urandom_range(2, 24), 60, 35);

    start_i <= 1'b0;
    wait_drained();
    repeat (64) @(posedge clk_i);
    if (book.mismatches == 0 && book.pending_colors.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/jca_pkg.sv
hw/rtl/jca_divider.sv
hw/rtl/jca_value_store.sv
hw/rtl/jca_color.sv
hw/rtl/jet_colormap_autorange.sv
bench/tb.sv
